FILE: sv/mbfa_pkg.sv
// ----------------------------------------------------------------------------
// mbfa_pkg
// shared types and constants for the multiword bit-field access block
// ----------------------------------------------------------------------------
package mbfa_pkg;

  localparam int unsigned STORE_WORDS_DEF = 1024;
  localparam int unsigned QUEUE_DEPTH     = 2;
  localparam int unsigned WORD_W          = 32;
  localparam int unsigned BIT_W           = 15;
  localparam int unsigned USED_W          = 11;
  localparam int unsigned OFF_W           = 5;

  typedef enum logic {
    OP_READ  = 1'b0,
    OP_WRITE = 1'b1
  } op_e;

  typedef struct packed {
    op_e               op;
    logic              err;
    logic              straddle;
    logic [OFF_W-1:0]  off;
    logic [WORD_W-1:0] fmask;
    logic [WORD_W-1:0] mask_lo;
    logic [WORD_W-1:0] mask_hi;
    logic [WORD_W-1:0] val_lo;
    logic [WORD_W-1:0] val_hi;
  } job_t;

endpackage

FILE: sv/mbfa_if.sv
// ----------------------------------------------------------------------------
// mbfa_if
// request and result channels of the multiword bit-field access block
// ----------------------------------------------------------------------------
interface mbfa_in_if import mbfa_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              operation;
  logic [BIT_W-1:0]  low_bit;
  logic [BIT_W-1:0]  end_bit;
  logic [WORD_W-1:0] write_value;

  modport source (output valid, operation, low_bit, end_bit, write_value, input ready);
  modport sink   (input valid, operation, low_bit, end_bit, write_value, output ready);
endinterface

interface mbfa_out_if import mbfa_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] read_value;
  logic [USED_W-1:0] used_words;
  logic              error;

  modport source (output valid, read_value, used_words, error, input ready);
  modport sink   (input valid, read_value, used_words, error, output ready);
endinterface

FILE: sv/mbfa_queue.sv
// ----------------------------------------------------------------------------
// mbfa_queue
// short fifo between the classifier and the store sequencer
// ----------------------------------------------------------------------------
module mbfa_queue import mbfa_pkg::*; #(
  parameter int unsigned DATA_W = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  output logic              full_o,
  input  logic [DATA_W-1:0] data_i,
  input  logic              pop_i,
  output logic              nonempty_o,
  output logic [DATA_W-1:0] data_o
);

  localparam int unsigned PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

  logic [DATA_W-1:0] slot_q [QUEUE_DEPTH];
  logic [PW-1:0]     wr_q, wr_d, rd_q, rd_d;
  logic [CW-1:0]     cnt_q, cnt_d;

  assign full_o     = (cnt_q == CW'(QUEUE_DEPTH));
  assign nonempty_o = (cnt_q != '0);
  assign data_o     = slot_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_q + 1'b1;
    end
    if (pop_i) begin
      rd_d = (rd_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_q] <= data_i;
    end
  end

endmodule

FILE: sv/mbfa_front.sv
// ----------------------------------------------------------------------------
// mbfa_front
// accepts requests, checks the field range and builds masks and addresses
// ----------------------------------------------------------------------------
module mbfa_front import mbfa_pkg::*; #(
  parameter int unsigned STORE_WORDS = STORE_WORDS_DEF
) (
  mbfa_in_if.sink                          in_i,
  input  logic                             clearing_i,
  input  logic                             q_full_i,
  output logic                             push_o,
  output job_t                             job_o,
  output logic [$clog2(STORE_WORDS)-1:0]   addr_o
);

  localparam int unsigned AW = $clog2(STORE_WORDS);
  localparam logic [31:0] BIT_LIMIT = 32'(STORE_WORDS * WORD_W);

  logic [BIT_W-1:0]  diff;
  logic [6:0]        span;
  logic [31:0]       blk32;
  logic [WORD_W-1:0] fmask;
  logic [63:0]       m64;
  logic [63:0]       v64;
  logic              bad;

  assign in_i.ready = !clearing_i && !q_full_i;
  assign push_o     = in_i.valid && in_i.ready;

  always_comb begin
    diff  = in_i.end_bit - in_i.low_bit;
    bad   = (in_i.end_bit < in_i.low_bit) || (diff > BIT_W'(WORD_W - 1))
         || ({17'd0, in_i.end_bit} >= BIT_LIMIT);
    span  = 7'(in_i.low_bit[OFF_W-1:0]) + 7'(diff[OFF_W-1:0]) + 7'd1;
    blk32 = {17'd0, in_i.low_bit} >> OFF_W;
    fmask = 32'hFFFF_FFFF >> (5'd31 - diff[OFF_W-1:0]);
    m64   = {32'd0, fmask} << in_i.low_bit[OFF_W-1:0];
    v64   = {32'd0, in_i.write_value & fmask} << in_i.low_bit[OFF_W-1:0];

    job_o.op       = op_e'(in_i.operation);
    job_o.err      = bad;
    job_o.straddle = (span > 7'(WORD_W));
    job_o.off      = in_i.low_bit[OFF_W-1:0];
    job_o.fmask    = fmask;
    job_o.mask_lo  = m64[31:0];
    job_o.mask_hi  = m64[63:32];
    job_o.val_lo   = v64[31:0];
    job_o.val_hi   = v64[63:32];
    addr_o         = blk32[AW-1:0];
  end

endmodule

FILE: sv/mbfa_back.sv
// ----------------------------------------------------------------------------
// mbfa_back
// word store sequencer: clearing sweep, read-modify-write and field extract
// ----------------------------------------------------------------------------
module mbfa_back import mbfa_pkg::*; #(
  parameter int unsigned STORE_WORDS = STORE_WORDS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           q_nonempty_i,
  output logic                           q_pop_o,
  input  job_t                           q_job_i,
  input  logic [$clog2(STORE_WORDS)-1:0] q_addr_i,
  output logic                           clearing_o,
  mbfa_out_if.source                     out_o
);

  localparam int unsigned AW = $clog2(STORE_WORDS);
  localparam int unsigned CW = $clog2(STORE_WORDS + 1);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_LO    = 3'd2;
  localparam logic [2:0] S_HI_RD = 3'd3;
  localparam logic [2:0] S_HI    = 3'd4;

  logic [WORD_W-1:0] mem_q [STORE_WORDS];
  logic [WORD_W-1:0] rdata_q;

  logic [2:0]        state_q, state_d;
  logic [AW-1:0]     clr_q, clr_d;
  job_t              item_q, item_d;
  logic [AW-1:0]     addr_q, addr_d;
  logic [WORD_W-1:0] lo_word_q, lo_word_d;
  logic [CW-1:0]     count_q, count_d;
  logic              out_valid_q, out_valid_d;
  logic [WORD_W-1:0] rv_q, rv_d;
  logic [USED_W-1:0] used_q, used_d;
  logic              err_q, err_d;

  logic              mem_we;
  logic [AW-1:0]     mem_addr;
  logic [WORD_W-1:0] mem_wdata;
  logic [AW-1:0]     addr_hi;
  logic              out_free;
  logic              finish;
  logic [31:0]       top32;
  logic [CW-1:0]     top_cnt;
  logic [CW-1:0]     cnt_next;
  logic [63:0]       joined;

  assign out_o.valid      = out_valid_q;
  assign out_o.read_value = rv_q;
  assign out_o.used_words = used_q;
  assign out_o.error      = err_q;
  assign clearing_o       = (state_q == S_CLEAR);
  assign out_free         = !out_valid_q || out_o.ready;
  assign addr_hi          = addr_q + 1'b1;

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    item_d      = item_q;
    addr_d      = addr_q;
    lo_word_d   = lo_word_q;
    count_d     = count_q;
    out_valid_d = out_valid_q && !out_o.ready;
    rv_d        = rv_q;
    used_d      = used_q;
    err_d       = err_q;
    mem_we      = 1'b0;
    mem_addr    = addr_q;
    mem_wdata   = '0;
    q_pop_o     = 1'b0;
    finish      = 1'b0;
    top32       = 32'(addr_q) + 32'd1;
    joined      = {rdata_q, lo_word_q} >> item_q.off;

    case (state_q)
      S_CLEAR: begin
        mem_we   = 1'b1;
        mem_addr = clr_q;
        if (clr_q == AW'(STORE_WORDS - 1)) begin
          state_d = S_IDLE;
        end else begin
          clr_d = clr_q + 1'b1;
        end
      end
      S_IDLE: begin
        mem_addr = q_addr_i;
        if (q_nonempty_i && out_free) begin
          q_pop_o = 1'b1;
          item_d  = q_job_i;
          addr_d  = q_addr_i;
          if (q_job_i.err) begin
            out_valid_d = 1'b1;
            rv_d        = '0;
            err_d       = 1'b1;
            used_d      = USED_W'(count_q);
          end else begin
            state_d = S_LO;
          end
        end
      end
      S_LO: begin
        if (item_q.op == OP_WRITE) begin
          mem_we    = 1'b1;
          mem_wdata = (rdata_q & ~item_q.mask_lo) | item_q.val_lo;
          if (item_q.straddle) begin
            state_d = S_HI_RD;
          end else begin
            finish = 1'b1;
            rv_d   = '0;
          end
        end else if (item_q.straddle) begin
          mem_addr  = addr_hi;
          lo_word_d = rdata_q;
          state_d   = S_HI;
        end else begin
          finish = 1'b1;
          rv_d   = (rdata_q >> item_q.off) & item_q.fmask;
        end
      end
      S_HI_RD: begin
        mem_addr = addr_hi;
        state_d  = S_HI;
      end
      S_HI: begin
        finish = 1'b1;
        if (item_q.op == OP_WRITE) begin
          mem_we    = 1'b1;
          mem_addr  = addr_hi;
          mem_wdata = (rdata_q & ~item_q.mask_hi) | item_q.val_hi;
          top32     = 32'(addr_q) + 32'd2;
          rv_d      = '0;
        end else begin
          rv_d = joined[31:0] & item_q.fmask;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    top_cnt  = top32[CW-1:0];
    cnt_next = count_q;
    if (finish && (item_q.op == OP_WRITE) && (top_cnt > count_q)) begin
      cnt_next = top_cnt;
    end
    if (finish) begin
      state_d     = S_IDLE;
      count_d     = cnt_next;
      out_valid_d = 1'b1;
      err_d       = 1'b0;
      used_d      = USED_W'(cnt_next);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q    <= item_d;
    addr_q    <= addr_d;
    lo_word_q <= lo_word_d;
    rv_q      <= rv_d;
    used_q    <= used_d;
    err_q     <= err_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_addr] <= mem_wdata;
    end
    rdata_q <= mem_q[mem_addr];
  end

  a_no_result_while_clearing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CLEAR) |-> !out_valid_q)
    else $error("result shown during clearing sweep");

  a_count_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(rst_ni) |-> (count_q >= $past(count_q)))
    else $error("used word count went down");

  a_write_only_for_writes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> ((state_q == S_CLEAR) || (item_q.op == OP_WRITE)))
    else $error("store written by a read");

  a_pop_only_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_o |-> ((state_q == S_IDLE) && q_nonempty_i))
    else $error("queue popped while busy or empty");

endmodule

FILE: sv/multiword_bit_field_access_top.sv
// ----------------------------------------------------------------------------
// multiword_bit_field_access_top
// bit-field insert and extract on a wide number kept as 32-bit words
// ----------------------------------------------------------------------------
// After reset the block sweeps the word store to zero, one word a cycle, and
// takes no request until that sweep is done. Requests are checked and turned
// into masks on the way in and wait in a two-entry queue; the store sequencer
// then works on one at a time through a single-port memory with registered
// read data. A field inside one word is read, then written or extracted; a
// straddling read reads both words, a straddling write reads and rewrites each
// word, a rejected range gets an error result straight from idle. The result
// stays in an output register until taken; the queue accepts until full.
module multiword_bit_field_access_top import mbfa_pkg::*; #(
  parameter int unsigned STORE_WORDS = STORE_WORDS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  mbfa_in_if.sink    in_i,
  mbfa_out_if.source out_o
);

  localparam int unsigned AW     = $clog2(STORE_WORDS);
  localparam int unsigned DATA_W = $bits(job_t) + AW;

  logic              clearing;
  logic              q_full;
  logic              push;
  job_t              f_job;
  logic [AW-1:0]     f_addr;
  logic              q_pop;
  logic              q_nonempty;
  logic [DATA_W-1:0] q_data;
  job_t              b_job;
  logic [AW-1:0]     b_addr;

  assign b_job  = job_t'(q_data[DATA_W-1:AW]);
  assign b_addr = q_data[AW-1:0];

  mbfa_front #(
    .STORE_WORDS (STORE_WORDS)
  ) u_front (
    .in_i       (in_i),
    .clearing_i (clearing),
    .q_full_i   (q_full),
    .push_o     (push),
    .job_o      (f_job),
    .addr_o     (f_addr)
  );

  mbfa_queue #(
    .DATA_W (DATA_W)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .full_o     (q_full),
    .data_i     ({f_job, f_addr}),
    .pop_i      (q_pop),
    .nonempty_o (q_nonempty),
    .data_o     (q_data)
  );

  mbfa_back #(
    .STORE_WORDS (STORE_WORDS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_nonempty_i (q_nonempty),
    .q_pop_o      (q_pop),
    .q_job_i      (b_job),
    .q_addr_i     (b_addr),
    .clearing_o   (clearing),
    .out_o        (out_o)
  );

endmodule
